>>> rtl/core/ssrs_pkg.sv
// ----------------------------------------------------------------------------
// SPI sensor read scheduler package
// Shared word types, action and source codes, command bytes and read lengths.
// ----------------------------------------------------------------------------
package ssrs_pkg;

    // Event codes carried in the input word.
    typedef enum logic [1:0] {
        ACT_ACCEL_READY = 2'd0,
        ACT_GYRO_READY  = 2'd1,
        ACT_XFER_DONE   = 2'd2,
        ACT_TASK_POLL   = 2'd3
    } t_action;

    // Source codes reported for a started transfer.
    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_GYRO  = 2'd1,
        SRC_ACCEL = 2'd2,
        SRC_TEMP  = 2'd3
    } t_source;

    // First byte sent for each source.
    localparam logic [7:0] CMD_GYRO  = 8'h82;
    localparam logic [7:0] CMD_ACCEL = 8'h92;
    localparam logic [7:0] CMD_TEMP  = 8'hA2;
    localparam logic [7:0] CMD_NONE  = 8'h00;

    // Transfer lengths in bytes.
    localparam logic [3:0] GYRO_READ_LENGTH  = 4'd8;
    localparam logic [3:0] ACCEL_READ_LENGTH = 4'd9;
    localparam logic [3:0] TEMP_READ_LENGTH  = 4'd4;
    localparam logic [3:0] LEN_NONE          = 4'd0;

    // Input word.
    typedef struct packed {
        t_action action;
        logic    dma_busy;
    } t_in_word;

    // Result word.
    typedef struct packed {
        t_source    start_source;
        logic [7:0] command_byte;
        logic [3:0] transfer_length;
        logic       release_gyro_select;
        logic       release_accel_select;
        logic       notify_pulse;
        logic       gyro_consumed;
        logic       accel_consumed;
        logic       temp_consumed;
    } t_out_word;

    // Control from the pipeline to the scheduler.
    typedef struct packed {
        logic fire;
        logic start_enable;
    } t_sched_ctl;

endpackage

>>> rtl/core/spi_sensor_read_scheduler.sv
// ----------------------------------------------------------------------------
// SPI sensor read scheduler
// Fixed-priority scheduler of shared-SPI reads for gyro, accel and temperature.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Word
//  in        input      i_in_valid / o_in_ready    t_in_word (action, dma_busy)
//  out       output     o_out_valid / i_out_ready  t_out_word (nine fields)
//  cfg       input      i_cfg_valid / o_cfg_ready  start_enable, 1 bit
//
//  Each event gives one result word. An accepted word sits in an input
//  register and is processed into the result register when that is free
//  or being emptied. One word per cycle is sustained unless the output
//  stalls. A stalled output holds the result; the input register still takes
//  one more word. Reset is synchronous and clears all flags and start_enable.
//
module spi_sensor_read_scheduler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ssrs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssrs_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import ssrs_pkg::*;

    logic       r_in_valid;
    t_in_word   r_in_word;
    logic       r_out_valid;
    t_out_word  r_out_word;
    logic       r_start_enable;
    logic       fire;
    t_sched_ctl ctl;
    t_out_word  result;

    // Processing happens when the result register is free or being emptied.
    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign ctl.fire         = fire;
    assign ctl.start_enable = r_start_enable;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_start_enable <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    // Flag core.
    ssrs_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_word  (r_in_word),
        .o_word  (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= result;
        end
    end

    // Only one source is ever transferring, so a completion releases at most one select.
    a_one_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.release_gyro_select
                          && o_out_word.release_accel_select))
        else $error("both chip selects released by one completion");

    // A poll result never carries a start or a notify.
    a_poll_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.gyro_consumed || o_out_word.accel_consumed
                         || o_out_word.temp_consumed))
        |-> (o_out_word.start_source == SRC_NONE && !o_out_word.notify_pulse))
        else $error("poll result mixed with start or notify");

    // A started transfer always has a nonzero length.
    a_start_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.start_source != SRC_NONE)
        |-> (o_out_word.transfer_length != LEN_NONE))
        else $error("transfer started with zero length");

    // A held input word is not lost while the result side is stalled.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid)
        else $error("input word dropped without processing");

endmodule

>>> rtl/core/ssrs_sched.sv
// ----------------------------------------------------------------------------
// SPI sensor read scheduler flag core
// Holds the per-source flags and computes the result word for one event.
// ----------------------------------------------------------------------------
module ssrs_sched (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssrs_pkg::t_sched_ctl i_ctl,
    input  ssrs_pkg::t_in_word i_word,
    output ssrs_pkg::t_out_word o_word
);
    import ssrs_pkg::*;

    // Flag registers: ready, transferring, done, and notify for the gyro.
    logic r_g_rdy, r_g_xfr, r_g_done, r_g_note;
    logic r_a_rdy, r_a_xfr, r_a_done;
    logic r_t_rdy, r_t_xfr, r_t_done;
    logic n_g_rdy, n_g_xfr, n_g_done, n_g_note;
    logic n_a_rdy, n_a_xfr, n_a_done;
    logic n_t_rdy, n_t_xfr, n_t_done;

    logic try_en;
    logic go_g, go_a, go_t;

    // Event processing: first step, optional start, then the final step.
    always_comb begin
        n_g_rdy  = r_g_rdy;
        n_g_xfr  = r_g_xfr;
        n_g_done = r_g_done;
        n_g_note = r_g_note;
        n_a_rdy  = r_a_rdy;
        n_a_xfr  = r_a_xfr;
        n_a_done = r_a_done;
        n_t_rdy  = r_t_rdy;
        n_t_xfr  = r_t_xfr;
        n_t_done = r_t_done;
        o_word   = '0;
        try_en   = 1'b0;
        go_g     = 1'b0;
        go_a     = 1'b0;
        go_t     = 1'b0;

        case (i_word.action)
            ACT_ACCEL_READY: begin
                n_a_rdy = 1'b1;
                n_t_rdy = 1'b1;
                try_en  = i_ctl.start_enable;
            end
            ACT_GYRO_READY: begin
                n_g_rdy = 1'b1;
                try_en  = i_ctl.start_enable;
            end
            ACT_XFER_DONE: begin
                // Every transferring source moves to done.
                o_word.release_gyro_select  = r_g_xfr;
                o_word.release_accel_select = r_a_xfr | r_t_xfr;
                n_g_done = r_g_done | r_g_xfr;
                n_a_done = r_a_done | r_a_xfr;
                n_t_done = r_t_done | r_t_xfr;
                n_g_xfr  = 1'b0;
                n_a_xfr  = 1'b0;
                n_t_xfr  = 1'b0;
                try_en   = 1'b1;
            end
            ACT_TASK_POLL: begin
                o_word.gyro_consumed  = r_g_note;
                o_word.accel_consumed = r_a_done;
                o_word.temp_consumed  = r_t_done;
                n_g_note = 1'b0;
                n_a_done = 1'b0;
                n_t_done = 1'b0;
            end
            default: begin
                try_en = 1'b0;
            end
        endcase

        // Fixed-priority start; a source is not blocked by its own flag.
        if (try_en && !i_word.dma_busy) begin
            go_g = n_g_rdy && !n_a_xfr && !n_t_xfr;
            go_a = !go_g && n_a_rdy && !n_g_xfr && !n_t_xfr;
            go_t = !go_g && !go_a && n_t_rdy && !n_g_xfr && !n_a_xfr;
        end

        if (go_g) begin
            n_g_rdy = 1'b0;
            n_g_xfr = 1'b1;
            o_word.start_source    = SRC_GYRO;
            o_word.command_byte    = CMD_GYRO;
            o_word.transfer_length = GYRO_READ_LENGTH;
        end else if (go_a) begin
            n_a_rdy = 1'b0;
            n_a_xfr = 1'b1;
            o_word.start_source    = SRC_ACCEL;
            o_word.command_byte    = CMD_ACCEL;
            o_word.transfer_length = ACCEL_READ_LENGTH;
        end else if (go_t) begin
            n_t_rdy = 1'b0;
            n_t_xfr = 1'b1;
            o_word.start_source    = SRC_TEMP;
            o_word.command_byte    = CMD_TEMP;
            o_word.transfer_length = TEMP_READ_LENGTH;
        end

        // A completion promotes gyro done to a notify pulse.
        if (i_word.action == ACT_XFER_DONE && n_g_done) begin
            n_g_done            = 1'b0;
            n_g_note            = 1'b1;
            o_word.notify_pulse = 1'b1;
        end
    end

    // Flags change only when an event is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_rdy  <= 1'b0;
            r_g_xfr  <= 1'b0;
            r_g_done <= 1'b0;
            r_g_note <= 1'b0;
            r_a_rdy  <= 1'b0;
            r_a_xfr  <= 1'b0;
            r_a_done <= 1'b0;
            r_t_rdy  <= 1'b0;
            r_t_xfr  <= 1'b0;
            r_t_done <= 1'b0;
        end else if (i_ctl.fire) begin
            r_g_rdy  <= n_g_rdy;
            r_g_xfr  <= n_g_xfr;
            r_g_done <= n_g_done;
            r_g_note <= n_g_note;
            r_a_rdy  <= n_a_rdy;
            r_a_xfr  <= n_a_xfr;
            r_a_done <= n_a_done;
            r_t_rdy  <= n_t_rdy;
            r_t_xfr  <= n_t_xfr;
            r_t_done <= n_t_done;
        end
    end

endmodule

>>> sim/spi_sensor_read_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI sensor read scheduler testbench
// Drives event words through the input channel and checks every result word
// against a flag-level predictor or a typed table row. The run starts with a
// directed table, then runs random phases, each under its own start_enable
// setting. Both channels idle and stall at random, except in one steady phase.
// ----------------------------------------------------------------------------
module spi_sensor_read_scheduler_tb;
    import ssrs_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam int          RANDOM_PHASES   = 6;
    localparam int          WORDS_PER_PHASE = 235;

    // Flag bit positions inside the per-source state.
    localparam int BIT_READY  = 0;
    localparam int BIT_XFER   = 1;
    localparam int BIT_DONE   = 2;
    localparam int BIT_NOTIFY = 3;

    localparam t_out_word QUIET_WORD = '0;

    // One row of the directed table: an event word or a start_enable write.
    typedef struct {
        logic      is_cfg;
        logic      cfg_value;
        t_in_word  word;
        logic      typed;
        t_out_word want;
    } t_stim_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data = 1'b0;

    // Predictor state, cleared as the block is at reset.
    logic [3:0] gyro_st = '0;
    logic [2:0] accel_st = '0;
    logic [2:0] temp_st = '0;
    logic       enable_st = 1'b0;

    t_out_word   pending_results[$];
    t_stim_row   stim_table[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic        steady = 1'b0;

    spi_sensor_read_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Prints one mismatch line and counts it.
    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Starts at most one transfer in priority order gyro, accel, temperature.
    function automatic void pick_start(input logic busy, inout t_out_word r);
        if (busy) return;
        if (gyro_st[BIT_READY] && !accel_st[BIT_XFER] && !temp_st[BIT_XFER]) begin
            gyro_st[BIT_READY] = 1'b0;
            gyro_st[BIT_XFER]  = 1'b1;
            r.start_source     = SRC_GYRO;
            r.command_byte     = CMD_GYRO;
            r.transfer_length  = GYRO_READ_LENGTH;
        end else if (accel_st[BIT_READY] && !gyro_st[BIT_XFER] && !temp_st[BIT_XFER]) begin
            accel_st[BIT_READY] = 1'b0;
            accel_st[BIT_XFER]  = 1'b1;
            r.start_source      = SRC_ACCEL;
            r.command_byte      = CMD_ACCEL;
            r.transfer_length   = ACCEL_READ_LENGTH;
        end else if (temp_st[BIT_READY] && !gyro_st[BIT_XFER] && !accel_st[BIT_XFER]) begin
            temp_st[BIT_READY] = 1'b0;
            temp_st[BIT_XFER]  = 1'b1;
            r.start_source     = SRC_TEMP;
            r.command_byte     = CMD_TEMP;
            r.transfer_length  = TEMP_READ_LENGTH;
        end
    endfunction

    // Applies one event word to the flags and returns the result word it gives.
    function automatic t_out_word schedule_event(input t_in_word w);
        t_out_word r;
        r = QUIET_WORD;
        case (w.action)
            ACT_ACCEL_READY: begin
                // Accel data ready also marks the temperature reading ready.
                accel_st[BIT_READY] = 1'b1;
                temp_st[BIT_READY]  = 1'b1;
                if (enable_st) pick_start(w.dma_busy, r);
            end
            ACT_GYRO_READY: begin
                gyro_st[BIT_READY] = 1'b1;
                if (enable_st) pick_start(w.dma_busy, r);
            end
            ACT_XFER_DONE: begin
                if (gyro_st[BIT_XFER]) begin
                    gyro_st[BIT_XFER]     = 1'b0;
                    gyro_st[BIT_DONE]     = 1'b1;
                    r.release_gyro_select = 1'b1;
                end
                if (accel_st[BIT_XFER]) begin
                    accel_st[BIT_XFER]     = 1'b0;
                    accel_st[BIT_DONE]     = 1'b1;
                    r.release_accel_select = 1'b1;
                end
                if (temp_st[BIT_XFER]) begin
                    temp_st[BIT_XFER]      = 1'b0;
                    temp_st[BIT_DONE]      = 1'b1;
                    r.release_accel_select = 1'b1;
                end
                // Completions try a start whatever start_enable says.
                pick_start(w.dma_busy, r);
                if (gyro_st[BIT_DONE]) begin
                    gyro_st[BIT_DONE]   = 1'b0;
                    gyro_st[BIT_NOTIFY] = 1'b1;
                    r.notify_pulse      = 1'b1;
                end
            end
            default: begin
                if (gyro_st[BIT_NOTIFY]) begin
                    gyro_st[BIT_NOTIFY] = 1'b0;
                    r.gyro_consumed     = 1'b1;
                end
                if (accel_st[BIT_DONE]) begin
                    accel_st[BIT_DONE] = 1'b0;
                    r.accel_consumed   = 1'b1;
                end
                if (temp_st[BIT_DONE]) begin
                    temp_st[BIT_DONE] = 1'b0;
                    r.temp_consumed   = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // Table row builders.
    function automatic t_stim_row ev(input t_action a, input logic busy);
        t_stim_row s;
        s.is_cfg        = 1'b0;
        s.cfg_value     = 1'b0;
        s.word.action   = a;
        s.word.dma_busy = busy;
        s.typed         = 1'b0;
        s.want          = QUIET_WORD;
        return s;
    endfunction

    function automatic t_stim_row ev_typed(input t_action a, input logic busy,
                                           input t_out_word want);
        t_stim_row s;
        s       = ev(a, busy);
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    function automatic t_stim_row cfg_row(input logic v);
        t_stim_row s;
        s           = ev(ACT_TASK_POLL, 1'b0);
        s.is_cfg    = 1'b1;
        s.cfg_value = v;
        return s;
    endfunction

    function automatic t_out_word started(input t_source src, input logic [7:0] cmd,
                                          input logic [3:0] len);
        t_out_word r;
        r                 = QUIET_WORD;
        r.start_source    = src;
        r.command_byte    = cmd;
        r.transfer_length = len;
        return r;
    endfunction

    // Sends one event word after a random gap and records what it should give.
    task automatic send_event(input t_in_word w, input logic typed, input t_out_word want);
        int        gap;
        t_out_word predicted;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < 35) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = schedule_event(w);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Lowers valid and waits until every expected result word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Writes start_enable through the configuration channel.
    task automatic write_enable(input logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        enable_st = v;
    endtask

    // Random event word, biased toward an idle channel so transfers start.
    function automatic t_in_word random_event();
        t_in_word    w;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25)      w.action = ACT_ACCEL_READY;
        else if (pick < 50) w.action = ACT_GYRO_READY;
        else if (pick < 80) w.action = ACT_XFER_DONE;
        else                w.action = ACT_TASK_POLL;
        w.dma_busy = ($urandom_range(99) < 25);
        return w;
    endfunction

    // Output side stalls at random outside the steady phase.
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 35);
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result word %h with nothing expected", o_out_word));
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.start_source !== want.start_source)
                    flag_error($sformatf("start_source got %0d want %0d",
                                         o_out_word.start_source, want.start_source));
                if (o_out_word.command_byte !== want.command_byte)
                    flag_error($sformatf("command_byte got %h want %h",
                                         o_out_word.command_byte, want.command_byte));
                if (o_out_word.transfer_length !== want.transfer_length)
                    flag_error($sformatf("transfer_length got %0d want %0d",
                                         o_out_word.transfer_length, want.transfer_length));
                if (o_out_word.release_gyro_select !== want.release_gyro_select)
                    flag_error($sformatf("release_gyro_select got %b want %b",
                                         o_out_word.release_gyro_select,
                                         want.release_gyro_select));
                if (o_out_word.release_accel_select !== want.release_accel_select)
                    flag_error($sformatf("release_accel_select got %b want %b",
                                         o_out_word.release_accel_select,
                                         want.release_accel_select));
                if (o_out_word.notify_pulse !== want.notify_pulse)
                    flag_error($sformatf("notify_pulse got %b want %b",
                                         o_out_word.notify_pulse, want.notify_pulse));
                if (o_out_word.gyro_consumed !== want.gyro_consumed)
                    flag_error($sformatf("gyro_consumed got %b want %b",
                                         o_out_word.gyro_consumed, want.gyro_consumed));
                if (o_out_word.accel_consumed !== want.accel_consumed)
                    flag_error($sformatf("accel_consumed got %b want %b",
                                         o_out_word.accel_consumed, want.accel_consumed));
                if (o_out_word.temp_consumed !== want.temp_consumed)
                    flag_error($sformatf("temp_consumed got %b want %b",
                                         o_out_word.temp_consumed, want.temp_consumed));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial begin
        t_stim_row row;
        logic      phase_enable;

        // Start_enable is clear after reset, so data-ready words start nothing.
        stim_table.push_back(ev_typed(ACT_TASK_POLL, 1'b0, QUIET_WORD));
        // Completion with nothing transferring, channel busy then idle.
        stim_table.push_back(ev_typed(ACT_XFER_DONE, 1'b1, QUIET_WORD));
        stim_table.push_back(ev_typed(ACT_XFER_DONE, 1'b0, QUIET_WORD));
        // Repeated gyro data ready changes nothing further.
        stim_table.push_back(ev_typed(ACT_GYRO_READY, 1'b0, QUIET_WORD));
        stim_table.push_back(ev_typed(ACT_GYRO_READY, 1'b0, QUIET_WORD));
        stim_table.push_back(ev_typed(ACT_ACCEL_READY, 1'b1, QUIET_WORD));
        // A completion with nothing in flight still starts the gyro.
        stim_table.push_back(ev_typed(ACT_XFER_DONE, 1'b0,
                                      started(SRC_GYRO, CMD_GYRO, GYRO_READ_LENGTH)));
        stim_table.push_back(ev(ACT_XFER_DONE, 1'b0));
        stim_table.push_back(ev(ACT_TASK_POLL, 1'b0));
        stim_table.push_back(ev(ACT_XFER_DONE, 1'b1));
        stim_table.push_back(ev(ACT_TASK_POLL, 1'b1));
        // Immediate starts from data-ready words.
        stim_table.push_back(cfg_row(1'b1));
        stim_table.push_back(ev_typed(ACT_GYRO_READY, 1'b0,
                                      started(SRC_GYRO, CMD_GYRO, GYRO_READ_LENGTH)));
        // The gyro restarts while its own transfer is still flagged.
        stim_table.push_back(ev(ACT_GYRO_READY, 1'b0));
        stim_table.push_back(ev(ACT_ACCEL_READY, 1'b0));
        stim_table.push_back(ev(ACT_XFER_DONE, 1'b0));
        stim_table.push_back(ev(ACT_ACCEL_READY, 1'b0));
        stim_table.push_back(ev(ACT_XFER_DONE, 1'b1));
        stim_table.push_back(ev(ACT_XFER_DONE, 1'b0));
        stim_table.push_back(ev(ACT_XFER_DONE, 1'b0));
        stim_table.push_back(ev(ACT_TASK_POLL, 1'b1));
        stim_table.push_back(ev(ACT_TASK_POLL, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k]) begin
            row = stim_table[k];
            if (row.is_cfg) begin
                drain_results();
                write_enable(row.cfg_value);
            end else begin
                send_event(row.word, row.typed, row.want);
            end
        end

        // Random phases: both settings, one phase without any idling.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            steady = (ph == 2);
            phase_enable = (ph < 4) ? ph[0] : logic'($urandom_range(1));
            write_enable(phase_enable);
            repeat (WORDS_PER_PHASE) send_event(random_event(), 1'b0, QUIET_WORD);
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> spi_sensor_read_scheduler.f
rtl/core/ssrs_pkg.sv
rtl/core/ssrs_sched.sv
rtl/core/spi_sensor_read_scheduler.sv
sim/spi_sensor_read_scheduler_tb.sv
